// ===== rtl/core/smx_pkg.sv =====
// Shared types, constants and codes for the stack machine executor.
// Depends on nothing; every other file in rtl/core but smx_ram imports it.
package smx_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // Field widths of the two channels.
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int DEPTH_W  = 5;
    localparam int STATUS_W = 2;

    // Instruction queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Instruction codes on the input channel.
    localparam logic [MODE_W-1:0] LDC = 3'd0;
    localparam logic [MODE_W-1:0] ADD = 3'd1;
    localparam logic [MODE_W-1:0] SUB = 3'd2;
    localparam logic [MODE_W-1:0] MUL = 3'd3;
    localparam logic [MODE_W-1:0] DIV = 3'd4;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_DIVZERO   = 2'd3
    } status_t;

    // Instruction class as decided by the front.
    typedef enum logic [2:0] {
        OPK_LOAD,
        OPK_ADD,
        OPK_SUB,
        OPK_MUL,
        OPK_DIV,
        OPK_NOP
    } op_kind_t;

    // One queued instruction.
    typedef struct packed {
        op_kind_t           kind;
        logic [DATA_W-1:0]  immediate;
    } q_item_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_OPER,
        BK_DIV
    } back_state_t;

    // Request from the back end to the divider.
    typedef struct packed {
        logic               start;
        logic [DATA_W-1:0]  left;
        logic [DATA_W-1:0]  right;
    } div_req_t;

    // Answer from the divider.
    typedef struct packed {
        logic               done;
        logic [DATA_W-1:0]  quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/smx_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependency.
module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/smx_front.sv =====
// Front end: accepts input transactions, classifies the instruction and
// holds it in a short queue for the back end. Depends on smx_pkg.
module smx_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [smx_pkg::MODE_W-1:0]   s_mode,
    input  logic signed [smx_pkg::DATA_W-1:0] s_immediate,
    output logic                         q_valid,
    input  logic                         q_pop,
    output smx_pkg::q_item_t             q_item
);
    import smx_pkg::*;

    q_item_t             fifo_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    op_kind_t            kind;
    logic                push;
    logic                pop;

    // Classify the instruction code; unused codes do nothing.
    always_comb begin
        case (s_mode)
            LDC:     kind = OPK_LOAD;
            ADD:     kind = OPK_ADD;
            SUB:     kind = OPK_SUB;
            MUL:     kind = OPK_MUL;
            DIV:     kind = OPK_DIV;
            default: kind = OPK_NOP;
        endcase
    end

    assign s_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;
    assign q_item  = fifo_mem[rd_ptr_reg];

    // Queue pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= '{kind: kind, immediate: s_immediate};
        end
    end

endmodule

// ===== rtl/core/smx_div.sv =====
// Iterative signed divider, truncating toward zero, one quotient bit per
// cycle over magnitudes with a final sign fix. Depends on smx_pkg.
module smx_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  smx_pkg::div_req_t req,
    output smx_pkg::div_rsp_t rsp
);
    import smx_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                neg_reg;
    logic [DATA_W-1:0]   rem_reg;
    logic [DATA_W-1:0]   quo_reg;
    logic [DATA_W-1:0]   div_reg;
    logic [DATA_W:0]     trial;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign trial = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, div_reg};

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

    // Control: busy flag, step counter and the completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(DATA_W - 1);
            end else if (busy_reg) begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load magnitudes at start, then one restoring step a cycle.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            neg_reg <= req.left[DATA_W-1] ^ req.right[DATA_W-1];
            quo_reg <= req.left[DATA_W-1] ? (DATA_W'(0) - req.left) : req.left;
            div_reg <= req.right[DATA_W-1] ? (DATA_W'(0) - req.right) : req.right;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (!trial[DATA_W]) begin
                rem_reg <= trial[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== rtl/core/smx_back.sv =====
// Back end: executes queued instructions against the stack and drives the
// result channel. Depends on smx_pkg, smx_ram and smx_div.
module smx_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  smx_pkg::q_item_t               q_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [smx_pkg::DATA_W-1:0] m_top_value,
    output logic [smx_pkg::DEPTH_W-1:0]    m_depth,
    output logic [smx_pkg::STATUS_W-1:0]   m_status
);
    import smx_pkg::*;

    // The top entry lives in top_reg; the RAM holds the entries beneath it.
    back_state_t         state_reg, state_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    logic [DATA_W-1:0]   top_reg, top_next;
    op_kind_t            kind_reg, kind_next;

    logic                m_valid_reg;
    logic [DATA_W-1:0]   out_top_reg;
    logic [DEPTH_W-1:0]  out_depth_reg;
    status_t             out_status_reg;

    logic                out_load;
    logic [DATA_W-1:0]   out_top_next;
    logic [SP_W-1:0]     out_sp_next;
    status_t             out_status_next;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [DATA_W-1:0]   ram_rd_data;
    logic [SP_W-1:0]     sp_minus1;
    logic [SP_W-1:0]     sp_minus2;

    div_req_t            dreq;
    div_rsp_t            drsp;
    logic                out_free;
    logic [DATA_W-1:0]   left;
    logic [DATA_W-1:0]   right;

    smx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (top_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    smx_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign sp_minus1 = sp_reg - SP_W'(1);
    assign sp_minus2 = sp_reg - SP_W'(2);
    assign left      = ram_rd_data;
    assign right     = top_reg;

    assign ram_wr_addr = sp_minus1[ADDR_W-1:0];
    assign ram_rd_addr = sp_minus2[ADDR_W-1:0];

    // Sequencer: next state, stack update, RAM and divider control.
    always_comb begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        top_next        = top_reg;
        kind_next       = kind_reg;
        q_pop           = 1'b0;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        dreq.start      = 1'b0;
        dreq.left       = left;
        dreq.right      = right;
        out_load        = 1'b0;
        out_top_next    = top_reg;
        out_sp_next     = sp_reg;
        out_status_next = ST_OK;

        case (state_reg)
            BK_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    case (q_item.kind)
                        OPK_LOAD: begin
                            out_load = 1'b1;
                            if (sp_reg == SP_W'(STACK_DEPTH)) begin
                                out_status_next = ST_OVERFLOW;
                            end else begin
                                // Spill the old top below the new one.
                                ram_wr_en    = (sp_reg != '0);
                                top_next     = q_item.immediate;
                                sp_next      = sp_reg + SP_W'(1);
                                out_top_next = q_item.immediate;
                                out_sp_next  = sp_reg + SP_W'(1);
                            end
                        end
                        OPK_ADD, OPK_SUB, OPK_MUL, OPK_DIV: begin
                            if (sp_reg < SP_W'(2)) begin
                                out_load        = 1'b1;
                                out_status_next = ST_UNDERFLOW;
                            end else begin
                                // Fetch the entry below the top.
                                ram_rd_en  = 1'b1;
                                kind_next  = q_item.kind;
                                state_next = BK_OPER;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end

            BK_OPER: begin
                case (kind_reg)
                    OPK_ADD: begin
                        out_load     = 1'b1;
                        top_next     = left + right;
                        sp_next      = sp_minus1;
                        out_top_next = left + right;
                        out_sp_next  = sp_minus1;
                        state_next   = BK_IDLE;
                    end
                    OPK_SUB: begin
                        out_load     = 1'b1;
                        top_next     = left - right;
                        sp_next      = sp_minus1;
                        out_top_next = left - right;
                        out_sp_next  = sp_minus1;
                        state_next   = BK_IDLE;
                    end
                    OPK_MUL: begin
                        out_load     = 1'b1;
                        top_next     = left * right;
                        sp_next      = sp_minus1;
                        out_top_next = left * right;
                        out_sp_next  = sp_minus1;
                        state_next   = BK_IDLE;
                    end
                    default: begin
                        // Divide: a zero divisor leaves the stack alone.
                        if (right == '0) begin
                            out_load        = 1'b1;
                            out_status_next = ST_DIVZERO;
                            state_next      = BK_IDLE;
                        end else begin
                            dreq.start = 1'b1;
                            state_next = BK_DIV;
                        end
                    end
                endcase
            end

            BK_DIV: begin
                if (drsp.done) begin
                    out_load     = 1'b1;
                    top_next     = drsp.quotient;
                    sp_next      = sp_minus1;
                    out_top_next = drsp.quotient;
                    out_sp_next  = sp_minus1;
                    state_next   = BK_IDLE;
                end
            end

            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: top of stack, operation and the result register.
    always_ff @(posedge aclk) begin
        top_reg  <= top_next;
        kind_reg <= kind_next;
        if (out_load) begin
            out_top_reg    <= (out_sp_next == '0) ? '0 : out_top_next;
            out_depth_reg  <= DEPTH_W'(out_sp_next);
            out_status_reg <= out_status_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_top_value = out_top_reg;
    assign m_depth     = out_depth_reg;
    assign m_status    = out_status_reg;

endmodule

// ===== rtl/core/stack_machine_executor.sv =====
// Top level of the stack machine executor: front end queue and back end.
// Depends on smx_pkg, smx_front and smx_back.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_mode, s_immediate
//   m_        out        m_valid/m_ready    m_top_value, m_depth, m_status
//
// The front end takes a transaction in any cycle its four-entry queue has room.
// In the back end a load, an unused code or a fault found at issue finishes at
// issue; add, subtract and multiply first read the entry below the top from the
// stack RAM, then compute; divide reads it too, then waits for the bit-serial
// divider. Reset empties the stack and the queue.
// A stalled result channel holds the back end; the queue keeps filling.
module stack_machine_executor (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [smx_pkg::MODE_W-1:0]         s_mode,
    input  logic signed [smx_pkg::DATA_W-1:0]  s_immediate,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [smx_pkg::DATA_W-1:0]  m_top_value,
    output logic [smx_pkg::DEPTH_W-1:0]        m_depth,
    output logic [smx_pkg::STATUS_W-1:0]       m_status
);
    import smx_pkg::*;

    logic    q_valid;
    logic    q_pop;
    q_item_t q_item;

    smx_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_immediate (s_immediate),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item)
    );

    smx_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_top_value (m_top_value),
        .m_depth     (m_depth),
        .m_status    (m_status)
    );

endmodule

// ===== test/tb_stack_machine_executor.sv =====
// Self-checking testbench for the stack machine executor: a directed program, then
// random expression programs under several idling patterns, checked against a shadow stack.
// Depends on smx_pkg and the stack_machine_executor RTL.
`timescale 1ns / 100ps

module tb_stack_machine_executor;
    import smx_pkg::*;

    // One instruction as offered on the input channel.
    typedef struct {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] imm;
    } instr_t;

    // One report of the stack after an instruction.
    typedef struct {
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
        status_t                  status;
    } stack_report_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [MODE_W-1:0]           s_mode = '0;
    logic signed [DATA_W-1:0]    s_immediate = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [DATA_W-1:0]    m_top_value;
    logic [DEPTH_W-1:0]          m_depth;
    logic [STATUS_W-1:0]         m_status;

    // Program waiting to be issued and stack reports waiting to be seen.
    instr_t                      instr_q[$];
    stack_report_t               report_q[$];
    instr_t                      drive_instr;

    // Shadow copy of the stack.
    logic [DATA_W-1:0]           shadow_stack[STACK_DEPTH];
    int unsigned                 shadow_sp = 0;

    int                          issued_count = 0;
    int                          accepted_count = 0;
    int                          result_count = 0;
    int                          mismatch_count = 0;
    int                          status_count[4] = '{0, 0, 0, 0};
    int                          send_idle_pct = 0;
    int                          recv_stall_pct = 0;
    int                          phase_id = 0;
    logic                        holdoff_active = 1'b0;

    stack_machine_executor u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_immediate (s_immediate),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_top_value (m_top_value),
        .m_depth     (m_depth),
        .m_status    (m_status)
    );

    // Clock and the single reset at the start of the run.
    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // Runs one instruction on the shadow stack and returns the report it produces.
    function automatic stack_report_t execute_instruction(input logic [MODE_W-1:0] mode,
                                                          input logic [DATA_W-1:0] imm);
        stack_report_t     rep;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] mag_l;
        logic [DATA_W-1:0] mag_r;
        logic              ok;
        rep.status = ST_OK;
        ok = 1'b1;
        res = '0;
        if (mode == LDC) begin
            if (shadow_sp >= STACK_DEPTH) begin
                rep.status = ST_OVERFLOW;
            end else begin
                shadow_stack[shadow_sp] = imm;
                shadow_sp++;
            end
        end else if (mode <= DIV) begin
            if (shadow_sp < 2) begin
                rep.status = ST_UNDERFLOW;
            end else begin
                rhs = shadow_stack[shadow_sp - 1];
                lhs = shadow_stack[shadow_sp - 2];
                case (mode)
                    ADD: res = lhs + rhs;
                    SUB: res = lhs - rhs;
                    MUL: res = lhs * rhs;
                    default: begin
                        if (rhs == '0) begin
                            ok = 1'b0;
                            rep.status = ST_DIVZERO;
                        end else begin
                            // Divide magnitudes, then restore the sign: truncates toward zero.
                            mag_l = lhs[DATA_W-1] ? ('0 - lhs) : lhs;
                            mag_r = rhs[DATA_W-1] ? ('0 - rhs) : rhs;
                            res = mag_l / mag_r;
                            if (lhs[DATA_W-1] != rhs[DATA_W-1]) res = '0 - res;
                        end
                    end
                endcase
                if (ok) begin
                    shadow_sp--;
                    shadow_stack[shadow_sp - 1] = res;
                end
            end
        end
        rep.top_value = (shadow_sp > 0) ? shadow_stack[shadow_sp - 1] : '0;
        rep.depth = DEPTH_W'(shadow_sp);
        return rep;
    endfunction

    // Driver: presents the next queued instruction at the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || accepted_count == issued_count) begin
            if (instr_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drive_instr = instr_q.pop_front();
                s_valid <= 1'b1;
                s_mode <= drive_instr.mode;
                s_immediate <= drive_instr.imm;
                issued_count++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a solid hold-off while one is active.
    always @(negedge aclk) begin
        if (!aresetn || holdoff_active) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long hold-off on the result channel at the start of the first random phase.
    initial begin
        while (phase_id != 1) @(posedge aclk);
        holdoff_active = 1'b1;
        repeat (400) @(posedge aclk);
        holdoff_active = 1'b0;
    end

    // Monitor: checks each result transaction, then records an accepted instruction.
    always @(posedge aclk) begin
        stack_report_t exp_rep;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            result_count++;
            status_count[m_status]++;
            if (report_q.size() == 0) begin
                $error("result transaction with no instruction outstanding");
                mismatch_count++;
            end else begin
                exp_rep = report_q.pop_front();
                if (m_top_value !== exp_rep.top_value) begin
                    $error("top_value: expected %0d, actual %0d", exp_rep.top_value,
                           m_top_value);
                    mismatch_count++;
                end
                if (m_depth !== exp_rep.depth) begin
                    $error("depth: expected %0d, actual %0d", exp_rep.depth, m_depth);
                    mismatch_count++;
                end
                if (m_status !== exp_rep.status) begin
                    $error("status: expected %0d, actual %0d", exp_rep.status, m_status);
                    mismatch_count++;
                end
            end
        end
        if (aresetn && s_valid && s_ready === 1'b1) begin
            report_q.push_back(execute_instruction(s_mode, s_immediate));
            accepted_count++;
        end
    end

    function automatic void push_instr(input logic [MODE_W-1:0] mode,
                                       input logic [DATA_W-1:0] imm);
        instr_t it;
        it.mode = mode;
        it.imm = imm;
        instr_q.push_back(it);
    endfunction

    // Immediates lean toward small values and zero so divides do real work.
    function automatic logic [DATA_W-1:0] rand_imm();
        logic [DATA_W-1:0] v;
        case ($urandom_range(9))
            0: v = '0;
            1: begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'd1;
                endcase
            end
            2, 3, 4: v = DATA_W'($urandom_range(40)) - 32'd20;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [MODE_W-1:0] rand_binop();
        logic [MODE_W-1:0] op;
        case ($urandom_range(3))
            0: op = ADD;
            1: op = SUB;
            2: op = MUL;
            default: op = DIV;
        endcase
        return op;
    endfunction

    // Queues random programs: mostly expressions, with load bursts, drains and noise.
    task automatic queue_random_program(input int n);
        int added;
        int kind;
        int k;
        int ops;
        int j;
        added = 0;
        while (added < n) begin
            kind = $urandom_range(99);
            if (kind < 76) begin
                k = $urandom_range(6, 2);
                ops = k - 2 + $urandom_range(2);
                for (j = 0; j < k; j++) push_instr(LDC, rand_imm());
                for (j = 0; j < ops; j++) push_instr(rand_binop(), rand_imm());
                added += k + ops;
            end else if (kind < 84) begin
                k = $urandom_range(18, 8);
                for (j = 0; j < k; j++) push_instr(LDC, rand_imm());
                added += k;
            end else if (kind < 92) begin
                k = $urandom_range(16, 8);
                for (j = 0; j < k; j++) push_instr(rand_binop(), $urandom);
                added += k;
            end else begin
                k = $urandom_range(6, 1);
                for (j = 0; j < k; j++) push_instr(MODE_W'($urandom_range(7)), $urandom);
                added += k;
            end
        end
    endtask

    // The sender holds back until every outstanding report has arrived.
    task automatic wait_drained();
        while (instr_q.size() != 0 || accepted_count != issued_count || report_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic run_random_phase(input int id, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        phase_id = id;
        queue_random_program(130);
        wait_drained();
    endtask

    // Stimulus: directed program, then four random phases.
    initial begin
        int m;
        int j;
        while (!aresetn) @(posedge aclk);
        @(posedge aclk);

        // Empty stack: underflow with a zero top value.
        push_instr(ADD, '0);
        push_instr(LDC, 32'h8000_0000);
        // Only one entry: underflow on divide.
        push_instr(DIV, '0);
        push_instr(LDC, 32'hFFFF_FFFF);
        // Most negative value over minus one wraps.
        push_instr(DIV, 32'h7FFF_FFFF);
        push_instr(LDC, '0);
        // Divide by zero leaves both operands.
        push_instr(DIV, '0);
        // Unused codes do nothing.
        for (m = int'(DIV) + 1; m < 8; m++) push_instr(MODE_W'(m), $urandom);
        push_instr(SUB, '0);
        push_instr(LDC, 32'h7FFF_FFFF);
        push_instr(MUL, '0);
        // Fill the stack to the top, then overflow it.
        for (j = 0; j < 15; j++) begin
            case (j % 4)
                0: push_instr(LDC, 32'h7FFF_FFFF);
                1: push_instr(LDC, 32'h8000_0000);
                2: push_instr(LDC, 32'hFFFF_FFFF);
                default: push_instr(LDC, $urandom);
            endcase
        end
        push_instr(LDC, $urandom);
        push_instr(ADD, '0);
        wait_drained();

        run_random_phase(1, 0, 0);
        run_random_phase(2, 67, 0);
        run_random_phase(3, 0, 67);
        run_random_phase(4, 17, 17);

        // Let a late divide or a stray result show up.
        repeat (60) @(posedge aclk);
        $display("Ran %0d instructions over directed and four idling phases, with a long hold-off.",
                 accepted_count);
        $display("Results: %0d ok, %0d underflow, %0d overflow, %0d divide-by-zero.",
                 status_count[ST_OK], status_count[ST_UNDERFLOW], status_count[ST_OVERFLOW],
                 status_count[ST_DIVZERO]);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
